[sv/ohm_pkg.sv]
// Shared constants, types and hash functions of the ordered hash map.
`default_nettype none

package ohm_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int KEY_BITS      = 32;
  localparam int VALUE_BITS    = 32;
  localparam int SLOT_BITS     = $clog2(TABLE_ENTRIES);
  localparam int PROBE_BITS    = SLOT_BITS + 1;
  localparam int CNT_BITS      = SLOT_BITS + 1;
  localparam int SHIFT_BITS    = 5;
  localparam int CFG_IDX_BITS  = 1;
  // a new key is refused once the count reaches this
  localparam int FULL_LIMIT    = TABLE_ENTRIES - TABLE_ENTRIES / 4 - 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_HOME_SHIFT = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_STEP_SHIFT = 1'd1;

  localparam logic [SHIFT_BITS-1:0] HOME_SHIFT_RESET = 5'd4;
  localparam logic [SHIFT_BITS-1:0] STEP_SHIFT_RESET = 5'd8;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK_RD,
    ST_LOOK_CK,
    ST_PUSH_NEXT,
    ST_PUSH_RD,
    ST_PUSH_CK,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic                  rd_en;
    logic [SLOT_BITS-1:0]  rd_addr;
    logic                  key_we;
    logic                  val_we;
    logic [SLOT_BITS-1:0]  wr_addr;
    logic [KEY_BITS-1:0]   wr_key;
    logic [VALUE_BITS-1:0] wr_val;
  } mem_req_t;

  function automatic logic [SLOT_BITS-1:0] home_slot(input logic [KEY_BITS-1:0] k,
                                                     input logic [SHIFT_BITS-1:0] sh);
    logic [KEY_BITS-1:0] s;
    s = k >> sh;
    return s[SLOT_BITS-1:0];
  endfunction

  function automatic logic [SLOT_BITS-1:0] probe_step(input logic [KEY_BITS-1:0] k,
                                                      input logic [SHIFT_BITS-1:0] sh);
    logic [KEY_BITS-1:0] s;
    s = (k >> sh) | KEY_BITS'(1);
    return s[SLOT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

[sv/ohm_ram.sv]
// Simple dual-port RAM, one write and one registered read port.
`default_nettype none

module ohm_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/ohm_ctrl.sv]
// Probe and displacement sequencer with key store clearing and result register.
`default_nettype none

module ohm_ctrl (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic [ohm_pkg::SHIFT_BITS-1:0]      home_shift,
  input  wire logic [ohm_pkg::SHIFT_BITS-1:0]      step_shift,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                kind,
  input  wire logic [ohm_pkg::KEY_BITS-1:0]        key,
  input  wire logic [ohm_pkg::VALUE_BITS-1:0]      value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     found,
  output logic      [ohm_pkg::VALUE_BITS-1:0]      old_value,
  output logic                                     status,
  output ohm_pkg::mem_req_t                        mem,
  input  wire logic [ohm_pkg::KEY_BITS-1:0]        rd_key,
  input  wire logic [ohm_pkg::VALUE_BITS-1:0]      rd_val
);

  import ohm_pkg::*;

  state_t                state, state_next;
  logic [CNT_BITS-1:0]   count, count_next;
  logic [SLOT_BITS-1:0]  clr_addr, clr_addr_next;
  logic                  out_valid_next;

  logic                  op_kind, op_kind_next;
  logic [KEY_BITS-1:0]   op_key, op_key_next;
  logic [VALUE_BITS-1:0] op_val, op_val_next;
  logic [SLOT_BITS-1:0]  idx, idx_next;
  logic [SLOT_BITS-1:0]  step, step_next;
  logic [PROBE_BITS-1:0] probes, probes_next;
  logic [PROBE_BITS-1:0] moves, moves_next;
  logic [KEY_BITS-1:0]   ck, ck_next;
  logic [VALUE_BITS-1:0] cv, cv_next;
  logic                  res_found, res_found_next;
  logic [VALUE_BITS-1:0] res_old, res_old_next;
  logic                  res_status, res_status_next;
  logic                  load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      count     <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      probes    <= '0;
      moves     <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      clr_addr  <= clr_addr_next;
      out_valid <= out_valid_next;
      probes    <= probes_next;
      moves     <= moves_next;
    end
  end

  always_ff @(posedge clk) begin
    op_kind    <= op_kind_next;
    op_key     <= op_key_next;
    op_val     <= op_val_next;
    idx        <= idx_next;
    step       <= step_next;
    ck         <= ck_next;
    cv         <= cv_next;
    res_found  <= res_found_next;
    res_old    <= res_old_next;
    res_status <= res_status_next;
    if (load_out) begin
      found     <= res_found;
      old_value <= res_old;
      status    <= res_status;
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    clr_addr_next   = clr_addr;
    op_kind_next    = op_kind;
    op_key_next     = op_key;
    op_val_next     = op_val;
    idx_next        = idx;
    step_next       = step;
    probes_next     = probes;
    moves_next      = moves;
    ck_next         = ck;
    cv_next         = cv;
    res_found_next  = res_found;
    res_old_next    = res_old;
    res_status_next = res_status;
    in_stall        = 1'b1;
    load_out        = 1'b0;
    mem             = '0;
    mem.rd_addr     = idx;
    mem.wr_addr     = idx;

    case (state)
      ST_CLEAR: begin
        mem.key_we    = 1'b1;
        mem.wr_addr   = clr_addr;
        mem.wr_key    = '0;
        clr_addr_next = clr_addr + SLOT_BITS'(1);
        if (clr_addr == SLOT_BITS'(TABLE_ENTRIES - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          op_kind_next    = kind;
          op_key_next     = key;
          op_val_next     = value;
          idx_next        = home_slot(key, home_shift);
          step_next       = probe_step(key, step_shift);
          probes_next     = '0;
          res_found_next  = 1'b0;
          res_old_next    = '0;
          res_status_next = 1'b0;
          state_next      = (key == '0) ? ST_RESULT : ST_LOOK_RD;
        end
      end

      ST_LOOK_RD: begin
        if (probes == PROBE_BITS'(TABLE_ENTRIES)) begin
          res_status_next = op_kind;
          state_next      = ST_RESULT;
        end else begin
          mem.rd_en  = 1'b1;
          state_next = ST_LOOK_CK;
        end
      end

      ST_LOOK_CK: begin
        if (rd_key == op_key) begin
          res_found_next = 1'b1;
          res_old_next   = rd_val;
          mem.val_we     = op_kind;
          mem.wr_val     = op_val;
          state_next     = ST_RESULT;
        end else if (rd_key < op_key) begin
          if (!op_kind) begin
            state_next = ST_RESULT;
          end else if (count >= CNT_BITS'(FULL_LIMIT)) begin
            res_status_next = 1'b1;
            state_next      = ST_RESULT;
          end else begin
            count_next  = count + CNT_BITS'(1);
            ck_next     = rd_key;
            cv_next     = rd_val;
            mem.key_we  = 1'b1;
            mem.val_we  = 1'b1;
            mem.wr_key  = op_key;
            mem.wr_val  = op_val;
            moves_next  = '0;
            state_next  = ST_PUSH_NEXT;
          end
        end else begin
          idx_next    = idx + step;
          probes_next = probes + PROBE_BITS'(1);
          state_next  = ST_LOOK_RD;
        end
      end

      ST_PUSH_NEXT: begin
        if (ck == '0 || moves == PROBE_BITS'(TABLE_ENTRIES)) begin
          state_next = ST_RESULT;
        end else begin
          step_next   = probe_step(ck, step_shift);
          probes_next = '0;
          state_next  = ST_PUSH_RD;
        end
      end

      ST_PUSH_RD: begin
        if (probes == PROBE_BITS'(TABLE_ENTRIES)) begin
          // no slot found for the carried entry: it is dropped
          state_next = ST_RESULT;
        end else begin
          mem.rd_en  = 1'b1;
          state_next = ST_PUSH_CK;
        end
      end

      ST_PUSH_CK: begin
        if (rd_key <= ck) begin
          mem.key_we = 1'b1;
          mem.val_we = 1'b1;
          mem.wr_key = ck;
          mem.wr_val = cv;
          ck_next    = rd_key;
          cv_next    = rd_val;
          moves_next = moves + PROBE_BITS'(1);
          state_next = ST_PUSH_NEXT;
        end else begin
          idx_next    = idx + step;
          probes_next = probes + PROBE_BITS'(1);
          state_next  = ST_PUSH_RD;
        end
      end

      ST_RESULT: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(FULL_LIMIT))
    else $error("entry count beyond load limit");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(count) |-> count == $past(count) + CNT_BITS'(1) && $past(state) == ST_LOOK_CK)
    else $error("entry count changed outside an insert");

  a_no_zero_key: assert property (@(posedge clk) disable iff (rst)
    mem.key_we && state != ST_CLEAR |-> mem.wr_key != '0)
    else $error("empty key written outside clearing");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    probes <= PROBE_BITS'(TABLE_ENTRIES) && moves <= PROBE_BITS'(TABLE_ENTRIES))
    else $error("probe or move counter overrun");

endmodule

`default_nettype wire

[sv/ordered_hash_map_top.sv]
// Top level of the ordered hash map: hash registers, key and value stores, sequencer.
//
//  channel  direction  handshake           word
//  in       input      in_valid/in_stall   kind, key, value
//  out      output     out_valid/out_stall found, old_value, status
//  cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A probe is a key store read, then the compare on the registered data.
// A search or replace ends at the probe that hits; an insert further walks the
// displacement chain, with a read and a compare per probe, a step per move and a last step to close it.
// After reset all 1024 key store slots are cleared, with in_stall high.
// One word is in work at a time; the next is taken while a result waits on out_stall.
`default_nettype none

module ordered_hash_map_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                kind,
  input  wire logic [ohm_pkg::KEY_BITS-1:0]        key,
  input  wire logic [ohm_pkg::VALUE_BITS-1:0]      value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     found,
  output logic      [ohm_pkg::VALUE_BITS-1:0]      old_value,
  output logic                                     status,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [ohm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [ohm_pkg::SHIFT_BITS-1:0]      cfg_data
);

  import ohm_pkg::*;

  logic [SHIFT_BITS-1:0] home_shift;
  logic [SHIFT_BITS-1:0] step_shift;
  mem_req_t              mem;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      home_shift <= HOME_SHIFT_RESET;
      step_shift <= STEP_SHIFT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HOME_SHIFT: home_shift <= cfg_data;
        REG_STEP_SHIFT: step_shift <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ohm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .home_shift (home_shift),
    .step_shift (step_shift),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .key        (key),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .old_value  (old_value),
    .status     (status),
    .mem        (mem),
    .rd_key     (rd_key),
    .rd_val     (rd_val)
  );

  ohm_ram #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (KEY_BITS)
  ) u_key_ram (
    .clk   (clk),
    .we    (mem.key_we),
    .waddr (mem.wr_addr),
    .wdata (mem.wr_key),
    .re    (mem.rd_en),
    .raddr (mem.rd_addr),
    .rdata (rd_key)
  );

  ohm_ram #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (VALUE_BITS)
  ) u_val_ram (
    .clk   (clk),
    .we    (mem.val_we),
    .waddr (mem.wr_addr),
    .wdata (mem.wr_val),
    .re    (mem.rd_en),
    .raddr (mem.rd_addr),
    .rdata (rd_val)
  );

endmodule

`default_nettype wire
